// File: hdl/tv_denoise_iterative_clip_unit_macros.svh
// Assertion macros used by the block's top-level RTL file.
// Depends on nothing; define ASSERT_OFF to drop every check.
`ifndef TV_DENOISE_ITERATIVE_CLIP_UNIT_MACROS_SVH
`define TV_DENOISE_ITERATIVE_CLIP_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define TVDIC_ASSERT(LBL, CLK, RSTN, PROP) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) PROP) \
    else $error("tvdic assertion failed");
`define TVDIC_ASSERT_IMP(LBL, CLK, RSTN, ANT, CON) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
    else $error("tvdic implication failed");
`else
`define TVDIC_ASSERT(LBL, CLK, RSTN, PROP)
`define TVDIC_ASSERT_IMP(LBL, CLK, RSTN, ANT, CON)
`endif

`endif

// File: hdl/tvdic_pkg.sv
// Types and constants of the 1-D total-variation denoiser.
// No dependencies.
package tvdic_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned DIV_IN_W = 34;
  localparam int unsigned PADDR_W  = 3;

  localparam logic REG_REGULARITY = 1'b0;
  localparam logic REG_ITERATIONS = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] denoised;
    logic                     out_last;
  } out_word_t;

endpackage

// File: hdl/tvdic_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tvdic_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tvdic_div3.sv
// Digit-serial round-to-nearest divide by three, one byte per cycle.
// Depends on tvdic_pkg.
module tvdic_div3 (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic signed [tvdic_pkg::DIV_IN_W-1:0]   dividend_i,
  output logic                                    done_o,
  output logic signed [tvdic_pkg::DATA_W-1:0]     quot_o
);
  import tvdic_pkg::*;

  localparam int unsigned NUM_W  = 40;
  localparam int unsigned DIGITS = NUM_W / 8;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [2:0]           cnt_q, cnt_d;
  logic [1:0]           rem_q, rem_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [NUM_W-1:0]     quo_q, quo_d;
  logic [9:0]           part;
  logic [19:0]          prod;
  logic [7:0]           qdig;
  logic [9:0]           back;
  logic signed [NUM_W-1:0] biased;

  // floor((d+1)/3): bias by three times 2^32 so the long division stays unsigned
  assign biased = NUM_W'(dividend_i) + NUM_W'(1'b1) + (NUM_W'(3) << 32);
  assign part   = {rem_q, num_q[NUM_W-1 -: 8]};
  assign prod   = 20'(part) * 20'd683;
  assign qdig   = prod[18:11];
  assign back   = part - 10'(10'(qdig) * 10'd3);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      num_d  = NUM_W'(biased);
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = back[1:0];
      num_d = num_q << 8;
      quo_d = {quo_q[NUM_W-9:0], qdig};
      cnt_d = 3'(cnt_q + 1'b1);
      if (cnt_q == 3'(DIGITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
  end

  // removing the bias of 2^32 leaves the low word unchanged
  assign done_o = done_q;
  assign quot_o = quo_q[DATA_W-1:0];

endmodule

// File: hdl/tv_denoise_iterative_clip_unit.sv
// 1-D total-variation denoiser by iterative clipping, top level.
// Depends on tvdic_pkg, tvdic_ram, tvdic_div3 and the assertion macros.
//
// Usage: samples (signed Q16.16) arrive on the input channel, one word per
// cycle, and load into the sample memory until a word flagged is_last, or the
// MAX_SAMPLES-th word, closes the block. in_stall_o then stays high while the
// block runs the configured number of sweeps and emits the result.
// Each sweep reads and updates the first sample without a divide; every other
// sample also waits in ST_DIV for the divide-by-three unit, which takes one
// byte a cycle. Emission passes each word through the registered memory read;
// the last word is flagged out_last. With zero iterations or a single sample
// the block returns its input unchanged.
// A stalled output word holds in the output register; once the last word is
// in that register the input side accepts the next block.
// Reset clears the control state and sets regularity to 1 and iterations to
// 10; the memories need no clearing, as the difference array reads as zero
// throughout the first sweep of each block.
// Registers: regularity at byte address 0, iterations at byte address 4.
`include "tv_denoise_iterative_clip_unit_macros.svh"

module tv_denoise_iterative_clip_unit #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tvdic_pkg::in_word_t                in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tvdic_pkg::out_word_t               out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tvdic_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import tvdic_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [2:0] {
    ST_LOAD, ST_RD, ST_EX, ST_DIV, ST_ERD, ST_EDAT
  } state_e;

  state_e                   state_q, state_d;
  logic [CW-1:0]            ld_cnt_q, ld_cnt_d;
  logic [CW-1:0]            n_q, n_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic [CFG_W-1:0]         sweep_q, sweep_d;
  logic [CFG_W-1:0]         regularity_q, regularity_d;
  logic [CFG_W-1:0]         iterations_q, iterations_d;
  logic signed [DATA_W-1:0] zprev_q, zprev_d;
  logic signed [DATA_W-1:0] zcur_q, zcur_d;
  logic signed [DATA_W-1:0] xprev_q, xprev_d;
  logic signed [DATA_W-1:0] x_q, x_d;
  logic                     out_valid_q, out_valid_d;
  out_word_t                out_data_q, out_data_d;

  logic                     in_acc;
  logic                     cfg_wr;
  logic [CW-1:0]            cnt_next;
  logic                     last_idx;
  logic                     out_free;

  logic                     ny_we;
  logic [AW-1:0]            ny_waddr;
  logic [2*DATA_W-1:0]      ny_wdata;
  logic [2*DATA_W-1:0]      ny_rdata;
  logic                     dual_we;
  logic [DATA_W-1:0]        dual_rdata;

  logic signed [DATA_W-1:0]   y_val;
  logic signed [DATA_W-1:0]   zc_val;
  logic signed [DATA_W-1:0]   zp_val;
  logic signed [DIV_IN_W-1:0] xsum;
  logic signed [DATA_W-1:0]   x_sat;
  logic signed [DIV_IN_W-1:0] diff;
  logic                       div_start;
  logic                       div_done;
  logic signed [DATA_W-1:0]   div_q;
  logic signed [DIV_IN_W-1:0] zsum;
  logic signed [DIV_IN_W-1:0] clip_pos;
  logic signed [DIV_IN_W-1:0] clip_neg;
  logic signed [DATA_W-1:0]   z_new;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign prdata      = {16'b0, (paddr[2] == REG_ITERATIONS) ? iterations_q : regularity_q};
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign cnt_next = CW'(ld_cnt_q + 1'b1);
  assign last_idx = (CW'(idx_q) == CW'(n_q - 1'b1));

  // sweep datapath
  assign y_val  = ny_rdata[2*DATA_W-1:DATA_W];
  assign zc_val = ((sweep_q == '0) || last_idx) ? '0 : dual_rdata;
  assign zp_val = (idx_q == '0) ? '0 : zprev_q;
  assign xsum   = DIV_IN_W'(y_val) - DIV_IN_W'(zp_val) + DIV_IN_W'(zc_val);
  always_comb begin
    if (xsum[DIV_IN_W-1:DATA_W-1] == '0 || xsum[DIV_IN_W-1:DATA_W-1] == '1) begin
      x_sat = xsum[DATA_W-1:0];
    end else if (xsum[DIV_IN_W-1]) begin
      x_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      x_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end
  assign diff      = DIV_IN_W'(x_sat) - DIV_IN_W'(xprev_q);
  assign div_start = (state_q == ST_EX) && (idx_q != '0);

  tvdic_div3 u_div3 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign zsum     = DIV_IN_W'(zprev_q) + DIV_IN_W'(div_q);
  assign clip_pos = DIV_IN_W'({regularity_q, 15'b0});
  assign clip_neg = -clip_pos;
  always_comb begin
    if (zsum > clip_pos) begin
      z_new = clip_pos[DATA_W-1:0];
    end else if (zsum < clip_neg) begin
      z_new = clip_neg[DATA_W-1:0];
    end else begin
      z_new = zsum[DATA_W-1:0];
    end
  end

  // sample memory holds {noisy, estimate} per entry
  assign ny_we    = in_acc || (state_q == ST_EX);
  assign ny_waddr = (state_q == ST_LOAD) ? ld_cnt_q[AW-1:0] : idx_q;
  assign ny_wdata = (state_q == ST_LOAD) ? {in_data_i.sample, in_data_i.sample}
                                         : {y_val, x_sat};
  assign dual_we  = (state_q == ST_DIV) && div_done;

  tvdic_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_SAMPLES)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ny_we),
    .waddr_i (ny_waddr),
    .wdata_i (ny_wdata),
    .raddr_i (idx_q),
    .rdata_o (ny_rdata)
  );

  tvdic_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SAMPLES)
  ) u_dual_ram (
    .clk_i   (clk_i),
    .we_i    (dual_we),
    .waddr_i (AW'(idx_q - 1'b1)),
    .wdata_i (z_new),
    .raddr_i (idx_q),
    .rdata_o (dual_rdata)
  );

  always_comb begin
    state_d      = state_q;
    ld_cnt_d     = ld_cnt_q;
    n_d          = n_q;
    idx_d        = idx_q;
    sweep_d      = sweep_q;
    regularity_d = regularity_q;
    iterations_d = iterations_q;
    zprev_d      = zprev_q;
    zcur_d       = zcur_q;
    xprev_d      = xprev_q;
    x_d          = x_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;

    if (cfg_wr) begin
      if (paddr[2] == REG_ITERATIONS) begin
        iterations_d = pwdata[CFG_W-1:0];
      end else begin
        regularity_d = pwdata[CFG_W-1:0];
      end
    end

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          ld_cnt_d = cnt_next;
          if (in_data_i.is_last || (cnt_next == CW'(MAX_SAMPLES))) begin
            ld_cnt_d = '0;
            n_d      = cnt_next;
            idx_d    = '0;
            sweep_d  = '0;
            if ((cnt_next < CW'(2)) || (iterations_q == '0)) begin
              state_d = ST_ERD;
            end else begin
              state_d = ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        state_d = ST_EX;
      end
      ST_EX: begin
        x_d    = x_sat;
        zcur_d = zc_val;
        if (idx_q == '0) begin
          xprev_d = x_sat;
          zprev_d = zc_val;
          idx_d   = AW'(idx_q + 1'b1);
          state_d = ST_RD;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          xprev_d = x_q;
          zprev_d = zcur_q;
          state_d = ST_RD;
          if (last_idx) begin
            idx_d = '0;
            if (CFG_W'(sweep_q + 1'b1) == iterations_q) begin
              sweep_d = '0;
              state_d = ST_ERD;
            end else begin
              sweep_d = CFG_W'(sweep_q + 1'b1);
            end
          end else begin
            idx_d = AW'(idx_q + 1'b1);
          end
        end
      end
      ST_ERD: begin
        if (out_free) begin
          state_d = ST_EDAT;
        end
      end
      ST_EDAT: begin
        out_valid_d = 1'b1;
        out_data_d  = '{denoised: ny_rdata[DATA_W-1:0], out_last: last_idx};
        if (last_idx) begin
          idx_d   = '0;
          state_d = ST_LOAD;
        end else begin
          idx_d   = AW'(idx_q + 1'b1);
          state_d = ST_ERD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      ld_cnt_q     <= '0;
      n_q          <= '0;
      idx_q        <= '0;
      sweep_q      <= '0;
      regularity_q <= CFG_W'(1);
      iterations_q <= CFG_W'(10);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ld_cnt_q     <= ld_cnt_d;
      n_q          <= n_d;
      idx_q        <= idx_d;
      sweep_q      <= sweep_d;
      regularity_q <= regularity_d;
      iterations_q <= iterations_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zprev_q    <= zprev_d;
    zcur_q     <= zcur_d;
    xprev_q    <= xprev_d;
    x_q        <= x_d;
    out_data_q <= out_data_d;
  end

  `TVDIC_ASSERT_IMP(a_out_from_emit, clk_i, rst_ni, $rose(out_valid_o), $past(state_q == ST_EDAT))
  `TVDIC_ASSERT_IMP(a_dual_wr_idx, clk_i, rst_ni, dual_we, idx_q != '0)
  `TVDIC_ASSERT_IMP(a_done_in_div, clk_i, rst_ni, div_done, state_q == ST_DIV)
  `TVDIC_ASSERT_IMP(a_idx_in_block, clk_i, rst_ni, state_q == ST_EX, CW'(idx_q) < n_q)

endmodule
